// ===== hw/rtl/cookie_header_tokenizer_defines.svh =====
// ----------------------------------------------------------------------------
// Cookie header tokenizer: assertion macros
// Shared concurrent assertion forms, all disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef COOKIE_HEADER_TOKENIZER_DEFINES_SVH
`define COOKIE_HEADER_TOKENIZER_DEFINES_SVH

// same-cycle implication
`define CHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg
// Types and constants shared by the cookie header tokenizer modules.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 12;
    localparam int POS_LIMIT   = (2 ** POS_W) - 1;
    localparam int MAX_HEADER_LEN = 4096;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CHAR_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CHAR_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_EQUAL  = 8'h3D;
    localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // byte class as seen by the back end
    typedef enum logic [2:0] {
        KIND_DQUOTE,
        KIND_SQUOTE,
        KIND_SEP,       // ';' or CR
        KIND_END,       // zero byte
        KIND_EQUAL,
        KIND_LF,
        KIND_SPACE,
        KIND_OTHER
    } cht_kind_t;

    // one classified byte in the queue
    typedef struct packed {
        cht_kind_t kind;
        logic      escaped;  // previous byte of the header was a backslash
    } cht_item_t;

    typedef struct packed {
        logic             operation;
        logic [POS_W-1:0] name_start;
        logic [POS_W-1:0] name_length;
        logic [POS_W-1:0] value_start;
        logic [POS_W-1:0] value_length;
    } cht_result_t;

endpackage

// ===== hw/rtl/cht_front.sv =====
// ----------------------------------------------------------------------------
// cht_front
// Accepts header bytes and classifies them; tracks the escape flag.
// ----------------------------------------------------------------------------
module cht_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [cht_pkg::BYTE_W-1:0] byte_in,
    output logic                       push,
    input  logic                       queue_ready,
    output cht_pkg::cht_item_t         item
);

    logic      bslash_reg;
    logic      bslash_next;
    logic      accept;
    cht_pkg::cht_kind_t kind;

    assign in_ready = queue_ready;
    assign accept   = in_valid && queue_ready;
    assign push     = accept;

    always_comb
    begin
        unique case (byte_in)
            cht_pkg::CHAR_DQUOTE: kind = cht_pkg::KIND_DQUOTE;
            cht_pkg::CHAR_SQUOTE: kind = cht_pkg::KIND_SQUOTE;
            cht_pkg::CHAR_SEMI:   kind = cht_pkg::KIND_SEP;
            cht_pkg::CHAR_CR:     kind = cht_pkg::KIND_SEP;
            cht_pkg::CHAR_NUL:    kind = cht_pkg::KIND_END;
            cht_pkg::CHAR_EQUAL:  kind = cht_pkg::KIND_EQUAL;
            cht_pkg::CHAR_LF:     kind = cht_pkg::KIND_LF;
            cht_pkg::CHAR_SPACE:  kind = cht_pkg::KIND_SPACE;
            default:              kind = cht_pkg::KIND_OTHER;
        endcase
    end

    assign item.kind    = kind;
    assign item.escaped = bslash_reg;

    // the end byte starts a new header, so the flag clears with it
    assign bslash_next = accept ? (byte_in == cht_pkg::CHAR_BSLASH) : bslash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bslash_reg <= 1'b0;
        end
        else
        begin
            bslash_reg <= bslash_next;
        end
    end

endmodule

// ===== hw/rtl/cht_queue.sv =====
// ----------------------------------------------------------------------------
// cht_queue
// Short register queue of classified bytes between front and back end.
// ----------------------------------------------------------------------------
`include "cookie_header_tokenizer_defines.svh"

module cht_queue
#(
    parameter int DEPTH = cht_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cht_pkg::cht_item_t push_item,
    output logic               not_full,
    input  logic               pop,
    output logic               not_empty,
    output cht_pkg::cht_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cht_pkg::cht_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign not_full  = (count_reg != CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `CHT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL, "queue count over depth")
    `CHT_ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && !push, count_reg == $past(count_reg) - 1'b1, "pop did not drain")
    `CHT_ASSERT_NOW(a_ptr_match, clk, rst_n, count_reg == '0, wr_ptr_reg == rd_ptr_reg, "empty queue with split pointers")

endmodule

// ===== hw/rtl/cht_back.sv =====
// ----------------------------------------------------------------------------
// cht_back
// Tokenizer state: quote modes, name/value spans, position; result register.
// ----------------------------------------------------------------------------
`include "cookie_header_tokenizer_defines.svh"

module cht_back
#(
    parameter int MAX_HEADER_LEN = cht_pkg::MAX_HEADER_LEN
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  cht_pkg::cht_item_t   item,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cht_pkg::cht_result_t result
);

    localparam int POS_W       = cht_pkg::POS_W;
    localparam int POS_MAX_INT = (MAX_HEADER_LEN - 1 < cht_pkg::POS_LIMIT)
                               ? MAX_HEADER_LEN - 1 : cht_pkg::POS_LIMIT;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(POS_MAX_INT);

    logic             dq_reg, dq_next;
    logic             sq_reg, sq_next;
    logic             name_phase_reg, name_phase_next;
    logic             value_phase_reg, value_phase_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic [POS_W-1:0] name_begin_reg, name_begin_next;
    logic [POS_W-1:0] name_count_reg, name_count_next;
    logic [POS_W-1:0] value_begin_reg, value_begin_next;
    logic [POS_W-1:0] value_count_reg, value_count_next;
    logic             out_valid_reg, out_valid_next;
    cht_pkg::cht_result_t result_reg, result_next;

    logic quoted;
    logic symbol;
    logic emit;
    logic clear_tok;
    logic is_add;

    assign pop       = item_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign quoted    = dq_reg || sq_reg;
    assign is_add    = (value_count_reg != '0);

    always_comb
    begin
        dq_next          = dq_reg;
        sq_next          = sq_reg;
        name_phase_next  = name_phase_reg;
        value_phase_next = value_phase_reg;
        position_next    = position_reg;
        name_begin_next  = name_begin_reg;
        name_count_next  = name_count_reg;
        value_begin_next = value_begin_reg;
        value_count_next = value_count_reg;
        symbol           = 1'b0;
        emit             = 1'b0;
        clear_tok        = 1'b0;

        if (pop)
        begin
            unique case (item.kind)
                cht_pkg::KIND_DQUOTE:
                begin
                    if (!item.escaped)
                    begin
                        dq_next = !dq_reg;
                    end
                    symbol = 1'b1;
                end
                cht_pkg::KIND_SQUOTE:
                begin
                    if (!item.escaped)
                    begin
                        sq_next = !sq_reg;
                    end
                    symbol = 1'b1;
                end
                cht_pkg::KIND_SEP:
                begin
                    if (!quoted)
                    begin
                        emit      = (name_count_reg != '0);
                        clear_tok = 1'b1;
                    end
                    else
                    begin
                        symbol = 1'b1;
                    end
                end
                cht_pkg::KIND_END:
                begin
                    emit = !quoted && (name_count_reg != '0);
                end
                cht_pkg::KIND_EQUAL:
                begin
                    if (!quoted)
                    begin
                        name_phase_next  = 1'b0;
                        value_phase_next = 1'b1;
                        value_begin_next = '0;
                        value_count_next = '0;
                    end
                    else
                    begin
                        symbol = 1'b1;
                    end
                end
                cht_pkg::KIND_LF:
                begin
                    symbol = 1'b0;
                end
                cht_pkg::KIND_SPACE:
                begin
                    symbol = name_phase_reg || value_phase_reg;
                end
                cht_pkg::KIND_OTHER:
                begin
                    symbol = 1'b1;
                end
            endcase

            if (clear_tok)
            begin
                dq_next          = 1'b0;
                sq_next          = 1'b0;
                name_phase_next  = 1'b0;
                value_phase_next = 1'b0;
                name_begin_next  = '0;
                name_count_next  = '0;
                value_begin_next = '0;
                value_count_next = '0;
            end

            if (symbol)
            begin
                if (value_phase_reg)
                begin
                    if (value_count_reg == '0)
                    begin
                        value_begin_next = position_reg;
                    end
                    value_count_next = (value_count_reg < POS_MAX)
                                     ? value_count_reg + 1'b1 : POS_MAX;
                end
                else
                begin
                    if (name_count_reg == '0)
                    begin
                        name_begin_next = position_reg;
                        name_phase_next = 1'b1;
                    end
                    name_count_next = (name_count_reg < POS_MAX)
                                    ? name_count_reg + 1'b1 : POS_MAX;
                end
            end

            // end byte: whole header state back to reset
            if (item.kind == cht_pkg::KIND_END)
            begin
                dq_next          = 1'b0;
                sq_next          = 1'b0;
                name_phase_next  = 1'b0;
                value_phase_next = 1'b0;
                name_begin_next  = '0;
                name_count_next  = '0;
                value_begin_next = '0;
                value_count_next = '0;
                position_next    = '0;
            end
            else
            begin
                position_next = (position_reg < POS_MAX) ? position_reg + 1'b1 : POS_MAX;
            end
        end
    end

    always_comb
    begin
        result_next              = result_reg;
        result_next.operation    = is_add ? cht_pkg::OP_ADD : cht_pkg::OP_DELETE;
        result_next.name_start   = name_begin_reg;
        result_next.name_length  = name_count_reg;
        result_next.value_start  = is_add ? value_begin_reg : '0;
        result_next.value_length = is_add ? value_count_reg : '0;

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dq_reg          <= 1'b0;
            sq_reg          <= 1'b0;
            name_phase_reg  <= 1'b0;
            value_phase_reg <= 1'b0;
            position_reg    <= '0;
            name_begin_reg  <= '0;
            name_count_reg  <= '0;
            value_begin_reg <= '0;
            value_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            dq_reg          <= dq_next;
            sq_reg          <= sq_next;
            name_phase_reg  <= name_phase_next;
            value_phase_reg <= value_phase_next;
            position_reg    <= position_next;
            name_begin_reg  <= name_begin_next;
            name_count_reg  <= name_count_next;
            value_begin_reg <= value_begin_next;
            value_count_reg <= value_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    `CHT_ASSERT_NEXT(a_end_clears, clk, rst_n, pop && item.kind == cht_pkg::KIND_END, position_reg == '0 && name_count_reg == '0, "end byte left state behind")
    `CHT_ASSERT_NOW(a_phase_has_name, clk, rst_n, name_phase_reg, name_count_reg != '0, "name phase with empty name")
    `CHT_ASSERT_NOW(a_pos_bound, clk, rst_n, 1'b1, position_reg <= POS_MAX && value_count_reg <= POS_MAX, "count past saturation limit")

endmodule

// ===== hw/rtl/cookie_header_tokenizer.sv =====
// ----------------------------------------------------------------------------
// cookie_header_tokenizer
// Splits a cookie header byte stream into name/value spans.
// ----------------------------------------------------------------------------
//
//  channel     | dir | tdata                                   | tuser
//  ------------+-----+-----------------------------------------+--------------
//  s_axis      | in  | [7:0] byte_in (0 ends the header)       | -
//  m_axis      | out | name_start, name_length, value_start,   | [0] operation
//              |     | value_length, 12 bits each, low first   |  (0 add, 1 del)
//
//  One byte per cycle is accepted sustained; a word is taken while a result
//  still waits on m_axis, as long as the 4-entry byte queue has room.
//  An accepted separator byte reaches its result word as the front classifies
//  it into the queue and the back end updates its state into the output register.
//  rst_n is asynchronous and clears all header state; there is no clearing
//  pass, the block takes bytes in the first cycle after reset.
//  A stall on m_axis backs up the queue; s_axis_tready drops when it is full.
//
module cookie_header_tokenizer
#(
    parameter int MAX_HEADER_LEN = cht_pkg::MAX_HEADER_LEN,
    parameter int QUEUE_DEPTH    = cht_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // name_start, name_length, value_start, value_length
    output logic [0:0]  m_axis_tuser    // [0] operation
);

    logic                 push;
    logic                 queue_ready;
    logic                 queue_valid;
    logic                 pop;
    cht_pkg::cht_item_t   front_item;
    cht_pkg::cht_item_t   back_item;
    cht_pkg::cht_result_t result;

    // front: classification and escape tracking
    cht_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .byte_in     (s_axis_tdata),
        .push        (push),
        .queue_ready (queue_ready),
        .item        (front_item)
    );

    // decouples input acceptance from the result side
    cht_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .not_full  (queue_ready),
        .pop       (pop),
        .not_empty (queue_valid),
        .pop_item  (back_item)
    );

    // back: tokenizer state and result register
    cht_back
    #(
        .MAX_HEADER_LEN (MAX_HEADER_LEN)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_valid),
        .item       (back_item),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .result     (result)
    );

    assign m_axis_tdata[11:0]  = result.name_start;
    assign m_axis_tdata[23:12] = result.name_length;
    assign m_axis_tdata[35:24] = result.value_start;
    assign m_axis_tdata[47:36] = result.value_length;
    assign m_axis_tuser[0]     = result.operation;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: cookie_header_tokenizer testbench
// Sends header bytes over s_axis and predicts each name/value span word
// with a bit-accurate tokenizer model held in a scoreboard. Words on m_axis
// are checked field by field in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;

    import cht_pkg::*;

    // position and span counts stop at this value
    localparam int POS_SAT = (MAX_HEADER_LEN - 1 < POS_LIMIT) ? MAX_HEADER_LEN - 1 : POS_LIMIT;

    // a separator reaches its result word by way of the byte queue and the output register
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 330;

    // ------------------------------------------------------------------------
    // scoreboard: tokenizer state plus the queue of span words still owed
    // ------------------------------------------------------------------------
    class cookie_scoreboard;
        bit                dq_open;
        bit                sq_open;
        bit                in_name;
        bit                in_value;
        logic [BYTE_W-1:0] last_byte;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  name_at;
        logic [POS_W-1:0]  name_len;
        logic [POS_W-1:0]  value_at;
        logic [POS_W-1:0]  value_len;
        cht_result_t       span_q[$];
        int                errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void clear_span();
            dq_open   = 1'b0;
            sq_open   = 1'b0;
            in_name   = 1'b0;
            in_value  = 1'b0;
            name_at   = '0;
            name_len  = '0;
            value_at  = '0;
            value_len = '0;
        endfunction

        function void restart();
            clear_span();
            last_byte = CHAR_NUL;
            pos       = '0;
        endfunction

        function logic [POS_W-1:0] bump(logic [POS_W-1:0] v);
            return (v < POS_SAT) ? v + 1'b1 : POS_SAT[POS_W-1:0];
        endfunction

        function int pending();
            return span_q.size();
        endfunction

        // advance the model by one accepted header byte
        function void note_byte(logic [BYTE_W-1:0] c);
            bit          quoted;
            bit          counts;
            cht_result_t r;
            quoted = dq_open || sq_open;
            counts = 1'b0;
            case (c)
                CHAR_DQUOTE:
                begin
                    if (last_byte != CHAR_BSLASH)
                        dq_open = !dq_open;
                    counts = 1'b1;
                end
                CHAR_SQUOTE:
                begin
                    if (last_byte != CHAR_BSLASH)
                        sq_open = !sq_open;
                    counts = 1'b1;
                end
                CHAR_SEMI, CHAR_CR, CHAR_NUL:
                begin
                    if (!quoted)
                    begin
                        // a span word only when a name was collected
                        if (name_len != 0)
                        begin
                            r.operation    = (value_len != 0) ? OP_ADD : OP_DELETE;
                            r.name_start   = name_at;
                            r.name_length  = name_len;
                            r.value_start  = (value_len != 0) ? value_at : '0;
                            r.value_length = value_len;
                            span_q.push_back(r);
                        end
                        clear_span();
                    end
                    else if (c != CHAR_NUL)
                        counts = 1'b1;
                end
                CHAR_EQUAL:
                begin
                    if (!quoted)
                    begin
                        // a second '=' restarts the value
                        in_name   = 1'b0;
                        in_value  = 1'b1;
                        value_at  = '0;
                        value_len = '0;
                    end
                    else
                        counts = 1'b1;
                end
                CHAR_LF:
                    counts = 1'b0;
                CHAR_SPACE:
                    counts = in_name || in_value;
                default:
                    counts = 1'b1;
            endcase

            if (counts)
            begin
                if (in_value)
                begin
                    if (value_len == 0)
                        value_at = pos;
                    value_len = bump(value_len);
                end
                else
                begin
                    if (name_len == 0)
                    begin
                        name_at = pos;
                        in_name = 1'b1;
                    end
                    name_len = bump(name_len);
                end
            end

            // end byte: quoted or not, the header is over
            if (c == CHAR_NUL)
                restart();
            else
            begin
                last_byte = c;
                pos       = bump(pos);
            end
        endfunction

        function void compare_field(string label, logic [POS_W-1:0] exp_v,
                                    logic [POS_W-1:0] act_v);
            if (exp_v !== act_v)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label,
                         exp_v, act_v);
                errors++;
            end
        endfunction

        // check one accepted m_axis word against the oldest expected span
        function void check_word(logic op, logic [47:0] data);
            cht_result_t e;
            if (span_q.size() == 0)
            begin
                $display("%0t: unexpected word, actual op=%0d data=%h", $time, op, data);
                errors++;
                return;
            end
            e = span_q.pop_front();
            compare_field("operation", POS_W'(e.operation), POS_W'(op));
            compare_field("name_start", e.name_start, data[11:0]);
            compare_field("name_length", e.name_length, data[23:12]);
            compare_field("value_start", e.value_start, data[35:24]);
            compare_field("value_length", e.value_length, data[47:36]);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] byte_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;            // name_start, name_length, value_start, value_length
    logic [0:0]  m_axis_tuser;            // [0] operation

    cookie_scoreboard sb = new();

    int send_gap_pct   = 0;   // chance in 100 that the sender idles a cycle
    int recv_stall_pct = 0;   // chance in 100 that the receiver stalls a cycle
    int bytes_sent     = 0;
    int cycles         = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cookie_header_tokenizer DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("cookie_header_tokenizer verification failed");
            $finish;
        end
    end

    // result side: check on handshake, then pick next cycle's tready
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tuser[0], m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // byte driver and header generators
    // ------------------------------------------------------------------------
    // one word on s_axis; tvalid stays up afterwards for back-to-back bytes
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // sender holds off until every owed span word has been taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly token characters, now and then a backslash, space or LF
    function automatic logic [7:0] token_byte();
        logic [7:0] b;
        case ($urandom_range(0, 19))
            0: return CHAR_BSLASH;
            1: return CHAR_SPACE;
            2: return CHAR_LF;
            default:
            begin
                do
                    b = 8'($urandom_range(1, 255));
                while (b == CHAR_DQUOTE || b == CHAR_SQUOTE || b == CHAR_SEMI ||
                       b == CHAR_CR || b == CHAR_EQUAL);
                return b;
            end
        endcase
    endfunction

    // well-formed header: name[=value] pairs split by ';' or CR LF, then NUL
    task automatic send_header();
        int         n_pairs;
        int         roll;
        logic [7:0] q;
        n_pairs = $urandom_range(1, 4);
        for (int p = 0; p < n_pairs; p++)
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_byte(CHAR_SPACE);
            repeat ($urandom_range(1, 6)) send_byte(token_byte());
            roll = $urandom_range(0, 9);
            if (roll < 7)
            begin
                send_byte(CHAR_EQUAL);
                if (roll == 0)
                begin
                    // quoted value, separators inside count as content
                    q = $urandom_range(0, 1) ? CHAR_DQUOTE : CHAR_SQUOTE;
                    send_byte(q);
                    repeat ($urandom_range(0, 5))
                        send_byte($urandom_range(0, 3) == 0 ? CHAR_SEMI : token_byte());
                    if ($urandom_range(0, 1))
                        send_byte(CHAR_EQUAL);
                    send_byte(q);
                end
                else
                    repeat ($urandom_range(0, 6)) send_byte(token_byte());
            end
            if (p != n_pairs - 1)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    send_byte(CHAR_CR);
                    send_byte(CHAR_LF);
                end
                else
                begin
                    send_byte(CHAR_SEMI);
                    if ($urandom_range(0, 1))
                        send_byte(CHAR_SPACE);
                end
            end
        end
        if ($urandom_range(0, 1))
            send_byte(CHAR_SEMI);
        send_byte(CHAR_NUL);
    endtask

    // broken input: raw bytes, unterminated quotes, stray separators
    task automatic send_noise();
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(0, 4))
                0: send_byte(CHAR_DQUOTE);
                1: send_byte(CHAR_SQUOTE);
                2: send_byte(CHAR_EQUAL);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
        if ($urandom_range(0, 1))
            send_byte(CHAR_NUL);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: leading space then add, CR delete, value with no name
        send_text(" a=b;");
        send_text("x\r");
        send_text("=v;");
        // second '=' restarts the value; end byte emits and clears
        send_text("k=1=2");
        send_byte(CHAR_NUL);
        // end byte inside quotes drops the header
        send_text("'q");
        send_byte(CHAR_NUL);
        // top byte value, escaped quote, skipped LF, then a bare separator
        send_byte(8'hFF);
        send_text("\\\"\n;;");
        send_byte(CHAR_NUL);

        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_gap_pct   = 37;
                    recv_stall_pct = 64;
                end
                1:
                begin
                    send_gap_pct   = 64;
                    recv_stall_pct = 37;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase

            bytes_sent = 0;
            while (bytes_sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 8)
                    send_header();
                else
                    send_noise();
            end
        end

        // flush any open header so every span is emitted
        send_byte(CHAR_NUL);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("cookie_header_tokenizer verification clean");
        else
            $display("cookie_header_tokenizer verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cht_pkg.sv
hw/rtl/cht_front.sv
hw/rtl/cht_queue.sv
hw/rtl/cht_back.sv
hw/rtl/cookie_header_tokenizer.sv
verif/tb.sv
